// ===== rtl/core/esg_pkg.sv =====
// Shared widths, reset values and codes for the encoder speed and gear block.
package esg_pkg;

   // Field and register widths.
   localparam int COUNT_W    = 16;
   localparam int STAMP_W    = 32;
   localparam int CMD_W      = 16;
   localparam int SPEED_W    = 32;
   localparam int GEAR_W     = 2;
   localparam int TPS_W      = 20;
   localparam int PPR_W      = 16;
   localparam int PERIM_W    = 16;
   localparam int DZ_W       = 20;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 20;

   // Register values after reset.
   localparam logic [TPS_W-1:0]   TPS_RESET   = 20'd1000;
   localparam logic [PPR_W-1:0]   PPR_RESET   = 16'd30;
   localparam logic [PERIM_W-1:0] PERIM_RESET = 16'd212;
   localparam logic [DZ_W-1:0]    DZ_RESET    = 20'd200;

   // Saturation limits of the speed magnitude.
   localparam logic [SPEED_W-1:0] SPEED_POS_CAP = 32'h7FFF_FFFF;
   localparam logic [SPEED_W-1:0] SPEED_NEG_CAP = 32'h8000_0000;

   typedef enum logic [GEAR_W-1:0] {
      GEAR_NEUTRAL = 2'd0,
      GEAR_DRIVE   = 2'd1,
      GEAR_REVERSE = 2'd2
   } gear_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_TICKS_PER_SECOND   = 2'd0,
      CSR_PULSES_PER_REV     = 2'd1,
      CSR_WHEEL_PERIMETER_MM = 2'd2,
      CSR_DEADZONE_MMPS      = 2'd3
   } csr_index_type;

endpackage

// ===== rtl/core/esg_channels.sv =====
// Valid/ready channel interfaces for samples, results and register writes.
interface esg_req_if;
   import esg_pkg::*;
   logic                     valid;
   logic                     ready;
   logic [COUNT_W-1:0]       encoder_count;
   logic [STAMP_W-1:0]       tick_stamp;
   logic signed [CMD_W-1:0]  motor_command;

   modport source (output valid, output encoder_count, output tick_stamp,
                   output motor_command, input ready);
   modport sink   (input valid, input encoder_count, input tick_stamp,
                   input motor_command, output ready);
endinterface

interface esg_rsp_if;
   import esg_pkg::*;
   logic                      valid;
   logic                      ready;
   logic signed [SPEED_W-1:0] wheel_speed;
   logic [GEAR_W-1:0]         gear;

   modport source (output valid, output wheel_speed, output gear, input ready);
   modport sink   (input valid, input wheel_speed, input gear, output ready);
endinterface

interface esg_csr_if;
   import esg_pkg::*;
   logic                  valid;
   logic                  ready;
   logic [CSR_IDX_W-1:0]  index;
   logic [CSR_DATA_W-1:0] data;

   modport source (output valid, output index, output data, input ready);
   modport sink   (input valid, input index, input data, output ready);
endinterface

// ===== rtl/core/encoder_speed_and_gear.sv =====
// A first sample goes straight to the result stage; any other sample passes through MUL1,
// DIV1, MUL2, CHECK and DIV2, and skips DIV2 when the speed saturates early.
// A new sample is taken only once the block is idle again, as the bit-serial shift-add
// multiplier and the restoring divider, which retire one bit per cycle, are shared.
// A sample with an unchanged timestamp finishes in its transfer cycle and gives no result.
// Synchronous reset restores the register defaults and clears the stored count and stamp.
module encoder_speed_and_gear #(
   parameter int COUNTER_BITS = 16
) (
   input  logic       clock,
   input  logic       reset,
   esg_req_if.sink    req_ch,
   esg_rsp_if.source  rsp_ch,
   esg_csr_if.sink    csr_ch
);
   import esg_pkg::*;

   // Datapath widths derived from the counter width.
   localparam int DW        = COUNTER_BITS + 2;
   localparam int MW        = COUNTER_BITS;
   localparam int QW        = MW + PERIM_W;
   localparam int PW        = QW + TPS_W;
   localparam int HW        = PW - STAMP_W;
   localparam int HCW       = (HW > STAMP_W) ? HW : STAMP_W;
   localparam int STEPS_MAX = (QW > STAMP_W) ? QW : STAMP_W;
   localparam int CNTW      = $clog2(STEPS_MAX);

   localparam logic [DW-1:0] CMASK   = DW'((64'd1 << COUNTER_BITS) - 64'd1);
   localparam logic [DW-1:0] HALF    = CMASK >> 1;
   localparam logic [DW-1:0] CMODULO = DW'(64'd1 << COUNTER_BITS);

   typedef enum logic [2:0] {
      S_IDLE,
      S_MUL1,
      S_DIV1,
      S_MUL2,
      S_CHECK,
      S_DIV2,
      S_DONE
   } state_type;

   state_type            state_ff, state_in;
   logic                 primed_ff, primed_in;
   logic [DW-1:0]        prev_count_ff, prev_count_in;
   logic [STAMP_W-1:0]   prev_stamp_ff, prev_stamp_in;
   logic [TPS_W-1:0]     tps_ff, tps_in;
   logic [PPR_W-1:0]     ppr_ff, ppr_in;
   logic [PERIM_W-1:0]   perim_ff, perim_in;
   logic [DZ_W-1:0]      dz_ff, dz_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic [SPEED_W-1:0]   speed_ff, speed_in;
   logic [GEAR_W-1:0]    gear_ff, gear_in;
   logic [PW-1:0]        acc_ff, acc_in;
   logic [PW-1:0]        mcand_ff, mcand_in;
   logic [TPS_W-1:0]     mplier_ff, mplier_in;
   logic [STAMP_W-1:0]   rem_ff, rem_in;
   logic [STAMP_W-1:0]   div_ff, div_in;
   logic [STAMP_W-1:0]   dticks_ff, dticks_in;
   logic [CNTW-1:0]      cnt_ff, cnt_in;
   logic                 neg_ff, neg_in;
   logic                 sat_ff, sat_in;
   logic                 cmd_nz_ff, cmd_nz_in;
   logic                 cmd_neg_ff, cmd_neg_in;

   // Sample decode: masked count, wrapped difference and tick delta.
   logic [DW-1:0]        cnt_masked;
   logic signed [DW-1:0] delta_raw;
   logic signed [DW-1:0] delta_wrap;
   logic [DW-1:0]        delta_abs;
   logic [MW-1:0]        dmag;
   logic                 delta_neg;
   logic [STAMP_W-1:0]   dticks;

   always_comb begin
      cnt_masked = DW'(req_ch.encoder_count) & CMASK;
      delta_raw  = $signed(cnt_masked - prev_count_ff);
      priority if (delta_raw > $signed(HALF)) begin
         delta_wrap = delta_raw - $signed(CMODULO);
      end else if (delta_raw < -$signed(HALF)) begin
         delta_wrap = delta_raw + $signed(CMODULO);
      end else begin
         delta_wrap = delta_raw;
      end
      delta_neg = delta_wrap[DW-1];
      delta_abs = delta_neg ? DW'(-delta_wrap) : DW'(delta_wrap);
      dmag      = delta_abs[MW-1:0];
      dticks    = req_ch.tick_stamp - prev_stamp_ff;
   end

   // Shared shift-add step and shared restoring divide step.
   logic [PW-1:0]      add_sum;
   logic               div_msb;
   logic [STAMP_W:0]   div_trial;
   logic               div_ge;
   logic [STAMP_W-1:0] rem_next;
   logic [HW-1:0]      prod_hi;
   logic               quot_overflow;

   always_comb begin
      add_sum   = acc_ff + mcand_ff;
      div_msb   = (state_ff == S_DIV1) ? acc_ff[QW-1] : acc_ff[STAMP_W-1];
      div_trial = {rem_ff, div_msb};
      div_ge    = div_trial >= {1'b0, div_ff};
      rem_next  = div_ge ? STAMP_W'(div_trial - {1'b0, div_ff}) : div_trial[STAMP_W-1:0];
      prod_hi   = acc_ff[PW-1:STAMP_W];
      // The quotient reaches 2^32 exactly when the upper product bits reach the divisor.
      quot_overflow = HCW'(prod_hi) >= HCW'(dticks_ff);
   end

   // Final saturation, sign and gear selection.
   logic [SPEED_W-1:0] quot;
   logic [SPEED_W-1:0] cap;
   logic [SPEED_W-1:0] smag;
   logic [SPEED_W-1:0] speed_out;
   gear_type           gear_out;

   always_comb begin
      quot      = acc_ff[SPEED_W-1:0];
      cap       = neg_ff ? SPEED_NEG_CAP : SPEED_POS_CAP;
      smag      = (sat_ff || (quot > cap)) ? cap : quot;
      speed_out = neg_ff ? (SPEED_W'(0) - smag) : smag;
      gear_out  = GEAR_NEUTRAL;
      if ((smag > SPEED_W'(dz_ff)) && cmd_nz_ff) begin
         gear_out = cmd_neg_ff ? GEAR_REVERSE : GEAR_DRIVE;
      end
   end

   logic rsp_load;

   // Sequencer and register write decode.
   always_comb begin
      state_in      = state_ff;
      primed_in     = primed_ff;
      prev_count_in = prev_count_ff;
      prev_stamp_in = prev_stamp_ff;
      tps_in        = tps_ff;
      ppr_in        = ppr_ff;
      perim_in      = perim_ff;
      dz_in         = dz_ff;
      speed_in      = speed_ff;
      gear_in       = gear_ff;
      acc_in        = acc_ff;
      mcand_in      = mcand_ff;
      mplier_in     = mplier_ff;
      rem_in        = rem_ff;
      div_in        = div_ff;
      dticks_in     = dticks_ff;
      cnt_in        = cnt_ff;
      neg_in        = neg_ff;
      sat_in        = sat_ff;
      cmd_nz_in     = cmd_nz_ff;
      cmd_neg_in    = cmd_neg_ff;
      rsp_load      = 1'b0;

      // Register writes.
      if (csr_ch.valid) begin
         unique case (csr_index_type'(csr_ch.index))
            CSR_TICKS_PER_SECOND:   tps_in   = csr_ch.data[TPS_W-1:0];
            CSR_PULSES_PER_REV:     ppr_in   = csr_ch.data[PPR_W-1:0];
            CSR_WHEEL_PERIMETER_MM: perim_in = csr_ch.data[PERIM_W-1:0];
            CSR_DEADZONE_MMPS:      dz_in    = csr_ch.data[DZ_W-1:0];
            default: ;
         endcase
      end

      unique case (state_ff)
         S_IDLE: begin
            if (req_ch.valid) begin
               if (!primed_ff) begin
                  // First sample: store it and report zero speed in neutral.
                  primed_in     = 1'b1;
                  prev_count_in = cnt_masked;
                  prev_stamp_in = req_ch.tick_stamp;
                  acc_in        = '0;
                  sat_in        = 1'b0;
                  neg_in        = 1'b0;
                  cmd_nz_in     = 1'b0;
                  state_in      = S_DONE;
               end else if (dticks != '0) begin
                  prev_count_in = cnt_masked;
                  prev_stamp_in = req_ch.tick_stamp;
                  dticks_in     = dticks;
                  neg_in        = delta_neg;
                  cmd_nz_in     = req_ch.motor_command != '0;
                  cmd_neg_in    = req_ch.motor_command[CMD_W-1];
                  acc_in        = '0;
                  mcand_in      = PW'(dmag);
                  mplier_in     = TPS_W'(perim_ff);
                  cnt_in        = CNTW'(PERIM_W - 1);
                  state_in      = S_MUL1;
               end
            end
         end
         S_MUL1, S_MUL2: begin
            // One multiplier bit per cycle.
            if (mplier_ff[0]) begin
               acc_in = add_sum;
            end
            mcand_in  = mcand_ff << 1;
            mplier_in = mplier_ff >> 1;
            cnt_in    = cnt_ff - 1'b1;
            if (cnt_ff == '0) begin
               if (state_ff == S_MUL1) begin
                  rem_in   = '0;
                  div_in   = (ppr_ff == '0) ? STAMP_W'(1) : STAMP_W'(ppr_ff);
                  cnt_in   = CNTW'(QW - 1);
                  state_in = S_DIV1;
               end else begin
                  state_in = S_CHECK;
               end
            end
         end
         S_DIV1: begin
            // One quotient bit per cycle; the quotient shifts into the accumulator.
            rem_in = rem_next;
            acc_in = {acc_ff[PW-2:0], div_ge};
            cnt_in = cnt_ff - 1'b1;
            if (cnt_ff == '0) begin
               mcand_in  = PW'({acc_ff[QW-2:0], div_ge});
               acc_in    = '0;
               mplier_in = tps_ff;
               cnt_in    = CNTW'(TPS_W - 1);
               state_in  = S_MUL2;
            end
         end
         S_CHECK: begin
            if (quot_overflow) begin
               sat_in   = 1'b1;
               state_in = S_DONE;
            end else begin
               sat_in   = 1'b0;
               rem_in   = STAMP_W'(prod_hi);
               div_in   = dticks_ff;
               cnt_in   = CNTW'(STAMP_W - 1);
               state_in = S_DIV2;
            end
         end
         S_DIV2: begin
            rem_in = rem_next;
            acc_in = {acc_ff[PW-2:0], div_ge};
            cnt_in = cnt_ff - 1'b1;
            if (cnt_ff == '0) begin
               state_in = S_DONE;
            end
         end
         S_DONE: begin
            // Load the output register once it is free.
            if (!rsp_valid_ff || rsp_ch.ready) begin
               rsp_load = 1'b1;
               speed_in = speed_out;
               gear_in  = gear_out;
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase

      // Output register occupancy.
      if (rsp_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ch.ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   // State, configuration and result registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         primed_ff     <= 1'b0;
         prev_count_ff <= '0;
         prev_stamp_ff <= '0;
         tps_ff        <= TPS_RESET;
         ppr_ff        <= PPR_RESET;
         perim_ff      <= PERIM_RESET;
         dz_ff         <= DZ_RESET;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         primed_ff     <= primed_in;
         prev_count_ff <= prev_count_in;
         prev_stamp_ff <= prev_stamp_in;
         tps_ff        <= tps_in;
         ppr_ff        <= ppr_in;
         perim_ff      <= perim_in;
         dz_ff         <= dz_in;
         rsp_valid_ff  <= rsp_valid_in;
         speed_ff      <= speed_in;
         gear_ff       <= gear_in;
         acc_ff        <= acc_in;
         mcand_ff      <= mcand_in;
         mplier_ff     <= mplier_in;
         rem_ff        <= rem_in;
         div_ff        <= div_in;
         dticks_ff     <= dticks_in;
         cnt_ff        <= cnt_in;
         neg_ff        <= neg_in;
         sat_ff        <= sat_in;
         cmd_nz_ff     <= cmd_nz_in;
         cmd_neg_ff    <= cmd_neg_in;
      end
   end

   // Port drive.
   assign req_ch.ready       = (state_ff == S_IDLE);
   assign csr_ch.ready       = 1'b1;
   assign rsp_ch.valid       = rsp_valid_ff;
   assign rsp_ch.wheel_speed = speed_ff;
   assign rsp_ch.gear        = gear_ff;

   // A first sample goes straight to the result stage and marks the block primed.
   a_first_sample: assert property (@(posedge clock) disable iff (reset)
      (req_ch.valid && req_ch.ready && !primed_ff) |=> (state_ff == S_DONE && primed_ff))
      else $error("first sample did not go straight to the result stage");

   // The divider remainder always stays below its divisor.
   a_rem_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_DIV1 || state_ff == S_DIV2) |-> (rem_ff < div_ff))
      else $error("divider remainder not below divisor");

   // A finished result waits while the output register is still taken.
   a_done_waits: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_DONE && rsp_valid_ff && !rsp_ch.ready) |=> (state_ff == S_DONE))
      else $error("result overwrote an untaken output");

   // A drive or reverse gear needs a nonzero speed.
   a_gear_speed: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && gear_ff != GEAR_NEUTRAL) |-> (speed_ff != '0))
      else $error("gear engaged at zero speed");

endmodule

// ===== tb/encoder_speed_and_gear_test.sv =====
// Self-checking testbench for the encoder speed and gear block.
module encoder_speed_and_gear_test;
   import esg_pkg::*;

   localparam int CYCLE_LIMIT   = 600000;
   localparam int SETTLE_CYCLES = 150;
   localparam int MAX_PRINTS    = 100;
   localparam int RANDOM_ITEMS  = 100;
   localparam longint COUNT_SPAN = longint'(1) << COUNT_W;
   localparam longint COUNT_HALF = (COUNT_SPAN - 1) / 2;

   typedef struct {
      logic [COUNT_W-1:0]      encoder_count;
      logic [STAMP_W-1:0]      tick_stamp;
      logic signed [CMD_W-1:0] motor_command;
   } wheel_sample_type;

   typedef struct {
      logic signed [SPEED_W-1:0] wheel_speed;
      gear_type                  gear;
   } wheel_reading_type;

   logic clock;
   logic reset;

   esg_req_if req_if ();
   esg_rsp_if rsp_if ();
   esg_csr_if csr_if ();

   encoder_speed_and_gear #(.COUNTER_BITS(COUNT_W)) i_dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_if),
      .rsp_ch (rsp_if),
      .csr_ch (csr_if)
   );

   wheel_sample_type  pending_samples[$];
   wheel_reading_type expected_readings[$];

   // Odometry state and register copies that the prediction runs on.
   logic [TPS_W-1:0]   odo_tps       = TPS_RESET;
   logic [PPR_W-1:0]   odo_ppr       = PPR_RESET;
   logic [PERIM_W-1:0] odo_perimeter = PERIM_RESET;
   logic [DZ_W-1:0]    odo_deadzone  = DZ_RESET;
   logic [COUNT_W-1:0] odo_last_count = '0;
   logic [STAMP_W-1:0] odo_last_stamp = '0;
   bit                 odo_primed     = 1'b0;

   // Stimulus bookkeeping.
   logic [COUNT_W-1:0] gen_count = '0;
   logic [STAMP_W-1:0] gen_stamp = '0;
   bit  steady_flow = 1'b0;
   bit  req_took    = 1'b0;
   int  mismatch_count = 0;
   int  cycle_count    = 0;

   // Free-running clock.
   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   // Known values on every input from time zero.
   initial begin
      reset                = 1'b1;
      req_if.valid         = 1'b0;
      req_if.encoder_count = '0;
      req_if.tick_stamp    = '0;
      req_if.motor_command = '0;
      rsp_if.ready         = 1'b0;
      csr_if.valid         = 1'b0;
      csr_if.index         = CSR_TICKS_PER_SECOND;
      csr_if.data          = '0;
   end

   // Reports a mismatch, up to MAX_PRINTS of them, and counts it.
   task automatic report_mismatch(input string what);
      if (mismatch_count < MAX_PRINTS)
         $display("MISMATCH at cycle %0d: %s", cycle_count, what);
      mismatch_count++;
   endtask

   // Works out the reading a sample causes and advances the odometry state.
   function automatic bit predict_reading(input wheel_sample_type s,
                                          output wheel_reading_type r);
      logic [STAMP_W-1:0] dticks;
      longint signed      delta;
      longint unsigned    dmag, pulses, dist_mm, quot, rem, smag, cap, div;
      bit                 neg;
      r.wheel_speed = '0;
      r.gear        = GEAR_NEUTRAL;
      if (!odo_primed) begin
         odo_last_count = s.encoder_count;
         odo_last_stamp = s.tick_stamp;
         odo_primed     = 1'b1;
         return 1'b1;
      end
      dticks = s.tick_stamp - odo_last_stamp;
      if (dticks == '0)
         return 1'b0;
      // Count difference folded into the half range of the counter.
      delta = $signed({48'd0, s.encoder_count}) - $signed({48'd0, odo_last_count});
      if (delta > COUNT_HALF)
         delta -= COUNT_SPAN;
      else if (delta < -COUNT_HALF)
         delta += COUNT_SPAN;
      odo_last_count = s.encoder_count;
      odo_last_stamp = s.tick_stamp;
      neg     = delta < 0;
      dmag    = neg ? longint'(-delta) : longint'(delta);
      pulses  = (odo_ppr == '0) ? 64'd1 : {48'd0, odo_ppr};
      dist_mm = (dmag * {48'd0, odo_perimeter}) / pulses;
      // Speed scaled by the tick rate, split so the product cannot overflow.
      cap  = neg ? 64'h8000_0000 : 64'h7FFF_FFFF;
      div  = {32'd0, dticks};
      quot = dist_mm / div;
      rem  = dist_mm % div;
      if (quot >= 64'h1_0000_0000 && odo_tps != '0)
         smag = cap;
      else
         smag = quot * {44'd0, odo_tps} + (rem * {44'd0, odo_tps}) / div;
      if (smag > cap)
         smag = cap;
      r.wheel_speed = neg ? -smag[SPEED_W-1:0] : smag[SPEED_W-1:0];
      if (smag > {44'd0, odo_deadzone} && s.motor_command != '0)
         r.gear = s.motor_command[CMD_W-1] ? GEAR_REVERSE : GEAR_DRIVE;
      return 1'b1;
   endfunction

   // Sample driver: holds an item until its transfer, and idles at random between items unless the flow is held steady.
   always @(negedge clock) begin : drive_samples
      logic next_valid;
      next_valid = req_if.valid;
      if (req_took) begin
         void'(pending_samples.pop_front());
         next_valid = 1'b0;
      end
      if (!reset && !next_valid && pending_samples.size() > 0) begin
         if (steady_flow || $urandom_range(99) >= 30)
            next_valid = 1'b1;
      end
      if (reset)
         next_valid = 1'b0;
      if (next_valid) begin
         req_if.encoder_count <= pending_samples[0].encoder_count;
         req_if.tick_stamp    <= pending_samples[0].tick_stamp;
         req_if.motor_command <= pending_samples[0].motor_command;
      end
      req_if.valid <= next_valid;
   end

   // Result receiver stalls at random unless the flow is held steady.
   always @(negedge clock) begin
      if (reset)
         rsp_if.ready <= 1'b0;
      else
         rsp_if.ready <= steady_flow || ($urandom_range(99) >= 30);
   end

   // Monitor: predicts on each sample transfer and checks each result transfer.
   always @(posedge clock) begin : watch_channels
      wheel_sample_type  seen;
      wheel_reading_type want;
      if (reset) begin
         req_took <= 1'b0;
      end else begin
         req_took <= req_if.valid && req_if.ready;
         if (req_if.valid && req_if.ready) begin
            seen.encoder_count = req_if.encoder_count;
            seen.tick_stamp    = req_if.tick_stamp;
            seen.motor_command = req_if.motor_command;
            if (predict_reading(seen, want))
               expected_readings.push_back(want);
         end
         if (rsp_if.valid && rsp_if.ready) begin
            if (expected_readings.size() == 0) begin
               report_mismatch($sformatf("result with none expected: speed %0d gear %0d",
                                         rsp_if.wheel_speed, rsp_if.gear));
            end else begin
               want = expected_readings.pop_front();
               if (rsp_if.wheel_speed !== want.wheel_speed)
                  report_mismatch($sformatf("speed %0d, expected %0d",
                                            rsp_if.wheel_speed, want.wheel_speed));
               if (rsp_if.gear !== want.gear)
                  report_mismatch($sformatf("gear %0d, expected %0d",
                                            rsp_if.gear, want.gear));
            end
         end
      end
   end

   // Run limit.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("DONE: errors detected");
         $finish;
      end
   end

   // One register write; the copy follows at the transfer.
   task automatic write_register(input csr_index_type idx, input logic [CSR_DATA_W-1:0] val);
      @(negedge clock);
      csr_if.valid <= 1'b1;
      csr_if.index <= idx;
      csr_if.data  <= val;
      @(posedge clock);
      while (!csr_if.ready)
         @(posedge clock);
      case (idx)
         CSR_TICKS_PER_SECOND:   odo_tps       = val[TPS_W-1:0];
         CSR_PULSES_PER_REV:     odo_ppr       = val[PPR_W-1:0];
         CSR_WHEEL_PERIMETER_MM: odo_perimeter = val[PERIM_W-1:0];
         CSR_DEADZONE_MMPS:      odo_deadzone  = val[DZ_W-1:0];
         default: ;
      endcase
      @(negedge clock);
      csr_if.valid <= 1'b0;
   endtask

   task automatic write_all(input logic [CSR_DATA_W-1:0] tps, input logic [CSR_DATA_W-1:0] ppr,
                            input logic [CSR_DATA_W-1:0] perim,
                            input logic [CSR_DATA_W-1:0] dz);
      write_register(CSR_TICKS_PER_SECOND, tps);
      write_register(CSR_PULSES_PER_REV, ppr);
      write_register(CSR_WHEEL_PERIMETER_MM, perim);
      write_register(CSR_DEADZONE_MMPS, dz);
   endtask

   // Waits until the block has drained and gone quiet.
   task automatic wait_for_quiet();
      while (pending_samples.size() != 0 || req_if.valid || expected_readings.size() != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic queue_sample(input logic [COUNT_W-1:0] cnt, input logic [STAMP_W-1:0] stamp,
                               input logic signed [CMD_W-1:0] cmd);
      wheel_sample_type s;
      s.encoder_count = cnt;
      s.tick_stamp    = stamp;
      s.motor_command = cmd;
      pending_samples.push_back(s);
      gen_count = cnt;
      gen_stamp = stamp;
   endtask

   // Next sample at a given count, a tick step after the last one.
   task automatic queue_step(input logic [COUNT_W-1:0] cnt, input logic [STAMP_W-1:0] dt,
                             input logic signed [CMD_W-1:0] cmd);
      queue_sample(cnt, gen_stamp + dt, cmd);
   endtask

   // Mostly steady wheel motion, with repeated stamps and jumps mixed in.
   task automatic queue_random_sample();
      int                      kind;
      int                      step;
      logic [STAMP_W-1:0]      dt;
      logic signed [CMD_W-1:0] cmd;
      kind = $urandom_range(99);
      cmd  = ($urandom_range(9) == 0) ? 16'sd0 : CMD_W'($urandom);
      if (kind < 75) begin
         step = $urandom_range(600) - 300;
         case ($urandom_range(3))
            0: dt = $urandom_range(1, 50);
            1: dt = $urandom_range(1, 2000);
            2: dt = $urandom_range(1, 100000);
            default: dt = $urandom;
         endcase
         if (dt == '0)
            dt = 1;
         queue_step(gen_count + COUNT_W'(step), dt, cmd);
      end else if (kind < 85) begin
         queue_step(gen_count + COUNT_W'($urandom_range(40)), '0, cmd);
      end else if (kind < 92) begin
         queue_step(COUNT_W'($urandom), $urandom_range(1, 64), cmd);
      end else begin
         queue_sample(COUNT_W'($urandom), $urandom, cmd);
      end
   endtask

   task automatic run_random_items(input int n);
      repeat (n) queue_random_sample();
   endtask

   task automatic write_random_config();
      logic [CSR_DATA_W-1:0] tps, ppr, perim, dz;
      tps   = $urandom_range(1) ? CSR_DATA_W'($urandom_range(1, 1000000))
                                : CSR_DATA_W'($urandom_range(1, 5000));
      ppr   = {4'($urandom), ($urandom_range(1) ? 16'($urandom_range(1, 65535))
                                                : 16'($urandom_range(1, 200)))};
      perim = {4'($urandom), 16'($urandom_range(1, 65535))};
      dz    = $urandom_range(1) ? CSR_DATA_W'($urandom_range(0, 5000))
                                : CSR_DATA_W'($urandom);
      write_all(tps, ppr, perim, dz);
   endtask

   // Stimulus sequence: directed cases, then random phases over several settings.
   initial begin
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Reset settings: first sample, repeated stamp, wraps, extremes, deadzone edge.
      queue_sample(16'hFFFF, 32'hFFFF_FFF0, 16'sh7FFF);
      queue_step(16'h1234, 32'd0, -16'sd1);
      queue_step(16'h0000, 32'h20, 16'sd100);
      queue_step(16'h7FFF, 32'd1, 16'sh8000);
      queue_step(16'hFFFF, 32'd1, 16'sh7FFF);
      queue_step(16'h7FFF, 32'd1, 16'sd0);
      queue_step(16'h0000, 32'd1000, 16'sd1);
      queue_step(16'h0000, 32'd1, -16'sd1);
      queue_step(16'd30, 32'd1060, 16'sd5);
      queue_step(16'd0, 32'd1050, -16'sd7);
      queue_step(16'd30, 32'd1050, 16'sd0);
      queue_step(16'h8000, 32'hFFFF_FFFF, 16'sd3);
      queue_step(16'h8000, 32'h8000_0000, -16'sd2);
      run_random_items(RANDOM_ITEMS);
      wait_for_quiet();

      // Largest scale: speeds saturate both ways.
      write_all(20'hFFFFF, 20'd1, 20'h0FFFF, 20'd0);
      queue_step(16'hFFFF, 32'd1, 16'sd1);
      queue_step(16'h7FFF, 32'd1, -16'sd1);
      queue_step(16'hFFFF, 32'd1, -16'sd1);
      queue_step(16'h0000, 32'hFFFF_FFFF, 16'sd9);
      queue_step(16'h0001, 32'd0, 16'sd9);
      run_random_items(RANDOM_ITEMS);
      wait_for_quiet();

      // Zero tick rate and zero pulse count, widest deadzone.
      write_all(20'd0, 20'd0, 20'd1, 20'hFFFFF);
      run_random_items(RANDOM_ITEMS);
      wait_for_quiet();

      // Smallest rate, upper data bits set on the narrow registers.
      write_all(20'd1, 20'hFFFFF, 20'hFFFFF, 20'd1000000);
      run_random_items(RANDOM_ITEMS);
      wait_for_quiet();

      write_random_config();
      run_random_items(RANDOM_ITEMS);
      wait_for_quiet();

      // A stretch where neither side idles.
      write_random_config();
      steady_flow = 1'b1;
      run_random_items(RANDOM_ITEMS);
      wait_for_quiet();
      steady_flow = 1'b0;

      write_all(TPS_RESET, PPR_RESET, PERIM_RESET, DZ_RESET);
      run_random_items(RANDOM_ITEMS);
      wait_for_quiet();

      if (mismatch_count == 0)
         $display("DONE: 0 errors");
      else
         $display("DONE: errors detected");
      $finish;
   end

endmodule

// ===== encoder_speed_and_gear.f =====
rtl/core/esg_pkg.sv
rtl/core/esg_channels.sv
rtl/core/encoder_speed_and_gear.sv
tb/encoder_speed_and_gear_test.sv
